FILE: hdl/b62_pkg.sv
// shared constants, types and the digit-to-ascii function for the base-62 encoder
package b62_pkg;

  localparam int MAX_DIGITS_DEF = 11;
  localparam int VALUE_W        = 64;
  localparam int DIGIT_W        = 6;
  localparam int CHAR_W         = 7;
  localparam int RADIX          = 62;
  localparam int HALF_RADIX     = RADIX / 2;

  // per-cycle control shared by every cell of the row
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

  // 0-9 -> '0'-'9', 10-35 -> 'a'-'z', 36-61 -> 'A'-'Z'
  function automatic logic [CHAR_W-1:0] glyph_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < DIGIT_W'(10)) begin
      glyph_of = dx + CHAR_W'(48);
    end else if (d < DIGIT_W'(36)) begin
      glyph_of = dx + CHAR_W'(87);
    end else if (d < DIGIT_W'(RADIX)) begin
      glyph_of = dx + CHAR_W'(29);
    end else begin
      glyph_of = CHAR_W'(48);
    end
  endfunction

endpackage

FILE: hdl/b62_cell.sv
// one base-62 digit cell: doubles its digit and adds the carry from the cell below
module b62_cell (
  input  logic                         clk,
  input  b62_pkg::cell_ctrl_t          ctrl,
  input  logic                         carry_in,
  output logic                         carry_out,
  output logic [b62_pkg::DIGIT_W-1:0]  digit
);
  import b62_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W:0]   doubled;

  // carry depends only on the held digit, so nothing ripples along the row
  assign carry_out = (digit_r >= DIGIT_W'(HALF_RADIX));
  assign doubled   = {digit_r, carry_in};

  always_comb begin
    if (carry_out) begin
      digit_nxt = DIGIT_W'(doubled - (DIGIT_W+1)'(RADIX));
    end else begin
      digit_nxt = DIGIT_W'(doubled);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit_r <= '0;
    end else if (ctrl.shift) begin
      digit_r <= digit_nxt;
    end
  end

  assign digit = digit_r;

endmodule

FILE: hdl/base62_encode_u64_top.sv
// base-62 encoder top level: bit-serial conversion into a row of digit cells, then emit
//
// A transaction is taken when start is high and busy is low. The 64-bit value is shifted
// in one bit per cycle, most significant first, into a row of base-62 digit cells; the
// ST_SIZE state then finds the leading digit, and the characters leave one per cycle,
// most significant first, each shown for exactly one cycle with out_strobe high and the
// final one with out_last_char high. A value has 1 to MAX_DIGITS characters; busy
// stays high, and no new value is taken, until its last character is emitted. The
// receiver cannot stall, so every strobed character must be captured when it appears. If
// the value needs more than MAX_DIGITS digits, only the low MAX_DIGITS digits are sent.
module base62_encode_u64_top #(
  parameter int MAX_DIGITS = b62_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [b62_pkg::VALUE_W-1:0]  in_value,
  output logic                         out_strobe,
  output logic [b62_pkg::CHAR_W-1:0]   out_digit_char,
  output logic                         out_last_char
);
  import b62_pkg::*;

  localparam int IDX_W     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int BIT_CNT_W = $clog2(VALUE_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SIZE,
    ST_EMIT
  } state_t;

  state_t               state_r;
  logic [VALUE_W-1:0]   value_r;
  logic [BIT_CNT_W-1:0] bit_cnt_r;
  logic                 overflow_r;
  logic [IDX_W-1:0]     slot_r;
  logic                 out_strobe_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_last_r;

  cell_ctrl_t           ctrl;
  logic [DIGIT_W-1:0]   digit [MAX_DIGITS];
  logic                 carry [MAX_DIGITS];
  logic [IDX_W-1:0]     top_idx;

  assign busy = (state_r != ST_IDLE);

  assign ctrl.clear = start && !busy;
  assign ctrl.shift = (state_r == ST_SHIFT);

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    b62_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .carry_in  ((i == 0) ? value_r[VALUE_W-1] : carry[(i == 0) ? 0 : i-1]),
      .carry_out (carry[i]),
      .digit     (digit[i])
    );
  end

  // highest nonzero cell; a carry out of the row means all cells are significant
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (digit[i] != '0) begin
        top_idx = IDX_W'(i);
      end
    end
    if (overflow_r) begin
      top_idx = IDX_W'(MAX_DIGITS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            value_r    <= in_value;
            bit_cnt_r  <= '0;
            overflow_r <= 1'b0;
            state_r    <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          value_r    <= {value_r[VALUE_W-2:0], 1'b0};
          bit_cnt_r  <= bit_cnt_r + 1'b1;
          overflow_r <= overflow_r | carry[MAX_DIGITS-1];
          if (bit_cnt_r == BIT_CNT_W'(VALUE_W - 1)) begin
            state_r <= ST_SIZE;
          end
        end
        ST_SIZE: begin
          slot_r  <= top_idx;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          out_strobe_r <= 1'b1;
          out_char_r   <= glyph_of(digit[slot_r]);
          out_last_r   <= (slot_r == '0);
          slot_r       <= slot_r - 1'b1;
          if (slot_r == '0) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_digit_char = out_char_r;
  assign out_last_char  = out_last_r;

endmodule
